[rtl/jlav_pkg.sv]
// jlav_pkg: shared types and constants for the joint-limit avoidance block
// no dependencies; imported by every module of the block

package jlav_pkg;

    // fixed field widths
    localparam int POS_W   = 32;
    localparam int GAIN_W  = 31;
    localparam int DIV_W   = 31;
    localparam int VEL_W   = 32;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // register reset values (1.0 in unsigned Q15.16)
    localparam logic [GAIN_W-1:0] GAIN_RST = 31'd65536;
    localparam logic [GAIN_W-1:0] VMAX_RST = 31'd65536;

    // register index, taken from paddr bit 2
    localparam logic REG_GAIN = 1'b0;
    localparam logic REG_VMAX = 1'b1;

    // job queue geometry
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // job class decided by the front end
    typedef enum logic [2:0] {
        CLS_ZERO     = 3'd0,
        CLS_POS_MAX  = 3'd1,
        CLS_NEG_MAX  = 3'd2,
        CLS_LOW_DIV  = 3'd3,
        CLS_HIGH_DIV = 3'd4
    } t_cls;

    // one classified job
    typedef struct packed {
        t_cls             cls;
        logic [DIV_W-1:0] gap;
        logic [DIV_W-1:0] region;
    } t_job;

    // queue status seen by the front end and the checks
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

[rtl/joint_limit_avoidance_velocity.sv]
// joint_limit_avoidance_velocity: repulsive velocity near joint limits, one word per joint
// path from input accept to result valid: the job queue, then 31 + FRAC_BITS divider stages,
//          then one output register
// throughput: one word per cycle unless the output stalls; fully pipelined divider, one quotient bit a stage
// the result register stalls the divider pipeline; the four-word queue absorbs short stalls
// reset: synchronous active-low; clears queue, pipeline valids and output valid, gain and
//        max_velocity return to 1.0
// depends on jlav_pkg, jlav_front, jlav_queue, jlav_back

module joint_limit_avoidance_velocity import jlav_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input word channel
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [POS_W-1:0] i_position,
    input  logic signed [POS_W-1:0] i_lower_limit,
    input  logic signed [POS_W-1:0] i_upper_limit,
    input  logic [DIV_W-1:0]        i_region_size,
    // result word channel
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [VEL_W-1:0] o_avoid_velocity,
    // register port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [PADDR_W-1:0]      paddr,
    input  logic [PDATA_W-1:0]      pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    // configuration registers
    logic [GAIN_W-1:0] r_gain;
    logic [GAIN_W-1:0] r_vmax;
    logic              w_wr;

    // front to queue to back
    logic   w_push;
    t_job   w_front_job;
    logic   w_q_valid;
    t_job   w_q_job;
    logic   w_pop;
    t_qstat w_qstat;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    // registers sit at 4-byte steps, so bit 2 picks the register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RST;
            r_vmax <= VMAX_RST;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_GAIN: r_gain <= pwdata[GAIN_W-1:0];
                REG_VMAX: r_vmax <= pwdata[GAIN_W-1:0];
                default:  r_gain <= r_gain;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_GAIN: prdata = {1'b0, r_gain};
            REG_VMAX: prdata = {1'b0, r_vmax};
            default:  prdata = '0;
        endcase
    end

    // front end: limit compares and distance, upper limit wins
    jlav_front u_front (
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_position    (i_position),
        .i_lower_limit (i_lower_limit),
        .i_upper_limit (i_upper_limit),
        .i_region_size (i_region_size),
        .i_qstat       (w_qstat),
        .o_push        (w_push),
        .o_job         (w_front_job)
    );

    // short queue decouples input acceptance from divider stalls
    jlav_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_job   (w_q_job),
        .o_qstat (w_qstat)
    );

    // back end: inv(d) and inv(region) in lockstep, then clamp and sign
    jlav_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_gain           (r_gain),
        .i_vmax           (r_vmax),
        .i_job_valid      (w_q_valid),
        .i_job            (w_q_job),
        .o_job_pop        (w_pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_avoid_velocity (o_avoid_velocity)
    );

    // queue never written while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_qstat.full)
        else $error("job queue written while full");

    // divider never pulls from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("job queue read while empty");

    // every result stays within the velocity clamp
    a_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_avoid_velocity <= $signed({1'b0, r_vmax}))
                     && (o_avoid_velocity >= -$signed({1'b0, r_vmax})))
        else $error("avoid velocity outside clamp");

endmodule

[rtl/jlav_front.sv]
// jlav_front: accepts input words and classifies them against the joint limits
// depends on jlav_pkg

module jlav_front import jlav_pkg::*; (
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [POS_W-1:0] i_position,
    input  logic signed [POS_W-1:0] i_lower_limit,
    input  logic signed [POS_W-1:0] i_upper_limit,
    input  logic [DIV_W-1:0]        i_region_size,
    input  t_qstat                  i_qstat,
    output logic                    o_push,
    output t_job                    o_job
);

    logic signed [POS_W+1:0] w_q;
    logic signed [POS_W+1:0] w_lo;
    logic signed [POS_W+1:0] w_hi;
    logic signed [POS_W+1:0] w_r;
    logic signed [POS_W+1:0] w_d_lo;
    logic signed [POS_W+1:0] w_d_hi;
    logic                    w_lo_out;
    logic                    w_lo_band;
    logic                    w_hi_out;
    logic                    w_hi_band;

    // 34-bit signed arithmetic, nothing wraps
    assign w_q    = {{2{i_position[POS_W-1]}}, i_position};
    assign w_lo   = {{2{i_lower_limit[POS_W-1]}}, i_lower_limit};
    assign w_hi   = {{2{i_upper_limit[POS_W-1]}}, i_upper_limit};
    assign w_r    = {3'b000, i_region_size};
    assign w_d_lo = w_q - w_lo;
    assign w_d_hi = w_hi - w_q;

    assign w_lo_out  = w_q < w_lo;
    assign w_lo_band = w_q < (w_lo + w_r);
    assign w_hi_out  = w_q > w_hi;
    assign w_hi_band = w_q > (w_hi - w_r);

    assign o_in_ready = !i_qstat.full;
    assign o_push     = i_in_valid && !i_qstat.full;

    always_comb begin
        o_job.region = i_region_size;
        o_job.gap    = i_region_size;
        // upper limit decides whenever it applies
        priority if (w_hi_out) begin
            o_job.cls = CLS_NEG_MAX;
        end else if (w_hi_band) begin
            o_job.gap = w_d_hi[DIV_W-1:0];
            o_job.cls = (w_d_hi == '0) ? CLS_NEG_MAX : CLS_HIGH_DIV;
        end else if (w_lo_out) begin
            o_job.cls = CLS_POS_MAX;
        end else if (w_lo_band) begin
            o_job.gap = w_d_lo[DIV_W-1:0];
            o_job.cls = (w_d_lo == '0) ? CLS_POS_MAX : CLS_LOW_DIV;
        end else begin
            o_job.cls = CLS_ZERO;
        end
    end

endmodule

[rtl/jlav_queue.sv]
// jlav_queue: short job queue between front end and divider pipeline
// depends on jlav_pkg

module jlav_queue import jlav_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_job   i_job,
    input  logic   i_pop,
    output logic   o_valid,
    output t_job   o_job,
    output t_qstat o_qstat
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;

    assign o_valid       = (r_count != '0);
    assign o_job         = r_mem[r_rptr];
    assign o_qstat.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_qstat.empty = (r_count == '0);

    always_comb begin
        n_count = r_count;
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

[rtl/jlav_back.sv]
// jlav_back: pipelined twin restoring divider, clamp and sign, output register
// depends on jlav_pkg

module jlav_back import jlav_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [GAIN_W-1:0]       i_gain,
    input  logic [GAIN_W-1:0]       i_vmax,
    input  logic                    i_job_valid,
    input  t_job                    i_job,
    output logic                    o_job_pop,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [VEL_W-1:0] o_avoid_velocity
);

    localparam int NW = GAIN_W + FRAC_BITS;

    // one quotient bit per stage: returns {qbit, remainder}
    function automatic logic [DIV_W:0] div_step(input logic [DIV_W-1:0] rem,
                                                input logic nbit,
                                                input logic [DIV_W-1:0] dvs);
        logic [DIV_W:0] trial;
        logic [DIV_W:0] diff;
        trial = {rem, nbit};
        diff  = trial - {1'b0, dvs};
        if (trial >= {1'b0, dvs}) begin
            div_step = {1'b1, diff[DIV_W-1:0]};
        end else begin
            div_step = {1'b0, trial[DIV_W-1:0]};
        end
    endfunction

    logic [NW-1:0]    w_num;
    logic             w_en;
    logic             r_v     [NW];
    t_cls             r_cls   [NW];
    logic [DIV_W-1:0] r_div_d [NW];
    logic [DIV_W-1:0] r_div_r [NW];
    logic [DIV_W-1:0] r_rem_d [NW];
    logic [DIV_W-1:0] r_rem_r [NW];
    logic [NW-1:0]    r_quo_d [NW];
    logic [NW-1:0]    r_quo_r [NW];

    logic                    r_out_valid;
    logic signed [VEL_W-1:0] r_vel;
    logic [NW-1:0]           w_diff;
    logic [DIV_W-1:0]        w_mag;
    logic [DIV_W-1:0]        w_sel;
    logic                    w_neg;
    logic [VEL_W-1:0]        w_ext;
    logic [VEL_W-1:0]        n_vel;

    // num = gain<<FRAC_BITS; user holds it constant while items fly, unchecked
    assign w_num     = {i_gain, {FRAC_BITS{1'b0}}};
    assign w_en      = !r_out_valid || i_out_ready;
    assign o_job_pop = w_en && i_job_valid;

    for (genvar s = 0; s < NW; s++) begin : g_stage
        logic             w_pv;
        t_cls             w_pcls;
        logic [DIV_W-1:0] w_pdiv_d;
        logic [DIV_W-1:0] w_pdiv_r;
        logic [DIV_W-1:0] w_prem_d;
        logic [DIV_W-1:0] w_prem_r;
        logic [NW-1:0]    w_pquo_d;
        logic [NW-1:0]    w_pquo_r;
        logic [DIV_W:0]   n_step_d;
        logic [DIV_W:0]   n_step_r;

        if (s == 0) begin : g_head
            assign w_pv     = i_job_valid;
            assign w_pcls   = i_job.cls;
            assign w_pdiv_d = i_job.gap;
            assign w_pdiv_r = i_job.region;
            assign w_prem_d = '0;
            assign w_prem_r = '0;
            assign w_pquo_d = '0;
            assign w_pquo_r = '0;
        end else begin : g_body
            assign w_pv     = r_v[s-1];
            assign w_pcls   = r_cls[s-1];
            assign w_pdiv_d = r_div_d[s-1];
            assign w_pdiv_r = r_div_r[s-1];
            assign w_prem_d = r_rem_d[s-1];
            assign w_prem_r = r_rem_r[s-1];
            assign w_pquo_d = r_quo_d[s-1];
            assign w_pquo_r = r_quo_r[s-1];
        end

        assign n_step_d = div_step(w_prem_d, w_num[NW-1-s], w_pdiv_d);
        assign n_step_r = div_step(w_prem_r, w_num[NW-1-s], w_pdiv_r);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (w_en) begin
                r_v[s] <= w_pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_cls[s]   <= w_pcls;
                r_div_d[s] <= w_pdiv_d;
                r_div_r[s] <= w_pdiv_r;
                r_rem_d[s] <= n_step_d[DIV_W-1:0];
                r_rem_r[s] <= n_step_r[DIV_W-1:0];
                r_quo_d[s] <= {w_pquo_d[NW-2:0], n_step_d[DIV_W]};
                r_quo_r[s] <= {w_pquo_r[NW-2:0], n_step_r[DIV_W]};
            end
        end
    end

    // d is below the band width, so the difference never goes negative
    assign w_diff = r_quo_d[NW-1] - r_quo_r[NW-1];
    assign w_mag  = (w_diff > {{(NW-DIV_W){1'b0}}, i_vmax}) ? i_vmax : w_diff[DIV_W-1:0];

    always_comb begin
        unique case (r_cls[NW-1])
            CLS_ZERO:     begin w_sel = '0;     w_neg = 1'b0; end
            CLS_POS_MAX:  begin w_sel = i_vmax; w_neg = 1'b0; end
            CLS_NEG_MAX:  begin w_sel = i_vmax; w_neg = 1'b1; end
            CLS_LOW_DIV:  begin w_sel = w_mag;  w_neg = 1'b0; end
            CLS_HIGH_DIV: begin w_sel = w_mag;  w_neg = 1'b1; end
            default:      begin w_sel = '0;     w_neg = 1'b0; end
        endcase
    end

    assign w_ext = {1'b0, w_sel};
    assign n_vel = w_neg ? (~w_ext + 1'b1) : w_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_v[NW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_vel <= n_vel;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_avoid_velocity = r_vel;

endmodule

[tb/sv/joint_limit_avoidance_velocity_tb.sv]
// joint_limit_avoidance_velocity_tb: self-checking bench for the joint-limit repulsion block
// drives joint words and register writes, predicts each velocity word and checks it in order
// depends on jlav_pkg and joint_limit_avoidance_velocity

module joint_limit_avoidance_velocity_tb;
    import jlav_pkg::*;

    localparam int FRAC    = 16;
    localparam int QONE    = 1 << FRAC;    // 1.0 in Q16.16
    localparam int N_PHASE = 7;
    localparam int N_RAND  = 130;          // random words per phase
    localparam int TAIL    = FRAC + 32 + 20; // pipeline latency plus margin

    // one joint word as the sender sees it
    typedef struct {
        logic signed [POS_W-1:0] position;
        logic signed [POS_W-1:0] lower_limit;
        logic signed [POS_W-1:0] upper_limit;
        logic [DIV_W-1:0]        region;
    } t_joint_word;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic signed [POS_W-1:0] i_position = '0;
    logic signed [POS_W-1:0] i_lower_limit = '0;
    logic signed [POS_W-1:0] i_upper_limit = '0;
    logic [DIV_W-1:0]        i_region_size = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic signed [VEL_W-1:0] o_avoid_velocity;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [PADDR_W-1:0]      paddr = '0;
    logic [PDATA_W-1:0]      pwdata = '0;
    logic [PDATA_W-1:0]      prdata;
    logic                    pready;

    // bench copy of the two registers, updated when a write lands
    logic [GAIN_W-1:0] cfg_gain = GAIN_RST;
    logic [GAIN_W-1:0] cfg_vmax = VMAX_RST;

    t_joint_word             joint_backlog[$];  // words waiting to be offered
    logic signed [VEL_W-1:0] vel_expected[$];   // predicted velocities, oldest first

    int unsigned n_queued = 0;     // words put in the backlog
    int unsigned n_taken = 0;      // words accepted by the block
    int unsigned n_bad = 0;        // mismatches of any kind
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned rx_hold_req = 0;  // long receiver stall, picked up by the hold counter
    int unsigned rx_hold_left = 0;
    bit          in_taken = 1'b0;  // current input word went in at the last rising edge

    joint_limit_avoidance_velocity #(.FRAC_BITS(FRAC)) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_position      (i_position),
        .i_lower_limit   (i_lower_limit),
        .i_upper_limit   (i_upper_limit),
        .i_region_size   (i_region_size),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_avoid_velocity(o_avoid_velocity),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- prediction

    // inverse-distance term: (gain << FRAC) / d, truncated, d > 0
    function automatic longint gain_over(input longint d);
        longint num;
        num = longint'(cfg_gain) << FRAC;
        return num / d;
    endfunction

    // repulsive velocity for one joint word under the current registers
    function automatic logic signed [VEL_W-1:0] repel_velocity(
        input logic signed [POS_W-1:0] q,
        input logic signed [POS_W-1:0] lo,
        input logic signed [POS_W-1:0] hi,
        input logic [DIV_W-1:0]        r
    );
        longint qq, ll, hh, rr, vm, v, d;
        qq = q;
        ll = lo;
        hh = hi;
        rr = r;
        vm = cfg_vmax;
        v  = 0;
        // lower side: past the limit or inside the band above it
        if (qq < ll) begin
            v = vm;
        end else if (qq < ll + rr) begin
            d = qq - ll;
            if (d == 0) begin
                v = vm;
            end else begin
                v = gain_over(d) - gain_over(rr);
                if (v > vm) v = vm;
            end
        end
        // upper side is evaluated last and overrides the lower result
        if (qq > hh) begin
            v = -vm;
        end else if (qq > hh - rr) begin
            d = hh - qq;
            if (d == 0) begin
                v = -vm;
            end else begin
                v = gain_over(rr) - gain_over(d);
                if (v < -vm) v = -vm;
            end
        end
        return v[VEL_W-1:0];
    endfunction

    task automatic flag(input string what, input logic [31:0] exp_v, input logic [31:0] got_v);
        n_bad++;
        if (n_bad <= 10)
            $display("mismatch (%s) at %0t: expected %h, got %h", what, $realtime, exp_v, got_v);
    endtask

    // ---------------------------------------------------------------- driver

    // input words and receiver ready change on the falling edge only
    always @(negedge i_clk) begin : driver
        t_joint_word w;
        if (i_rst_n) begin
            // a word stays on the bus until the block takes it
            if (!i_in_valid || in_taken) begin
                in_taken = 1'b0;
                if (joint_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    w = joint_backlog.pop_front();
                    i_position    <= w.position;
                    i_lower_limit <= w.lower_limit;
                    i_upper_limit <= w.upper_limit;
                    i_region_size <= w.region;
                    i_in_valid    <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // long receiver stall, counted here so the stimulus thread keeps feeding words
    always @(posedge i_clk) begin
        if (rx_hold_req != 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left--;
        end
    end

    // ---------------------------------------------------------------- monitor

    // results are checked before new words are predicted at the same edge
    always @(posedge i_clk) begin : monitor
        logic signed [VEL_W-1:0] want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (vel_expected.size() == 0) begin
                    flag("unexpected word", 'x, o_avoid_velocity);
                end else begin
                    want = vel_expected.pop_front();
                    if (o_avoid_velocity !== want)
                        flag("avoid_velocity", want, o_avoid_velocity);
                end
            end
            if (i_in_valid && o_in_ready) begin
                vel_expected.push_back(repel_velocity(i_position, i_lower_limit,
                                                      i_upper_limit, i_region_size));
                n_taken++;
                in_taken = 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic add_word(input logic [31:0] p, input logic [31:0] lo,
                            input logic [31:0] hi, input logic [31:0] r);
        t_joint_word w;
        w.position    = p;
        w.lower_limit = lo;
        w.upper_limit = hi;
        w.region      = r[DIV_W-1:0];
        joint_backlog.push_back(w);
        n_queued++;
    endtask

    // hand-picked joints around both limits, degenerate bands and full-range values
    task automatic queue_directed();
        add_word(-1,                0, 100 * QONE, QONE);   // just below lower limit
        add_word(0,                 0, 100 * QONE, QONE);   // on lower limit
        add_word(1,                 0, 100 * QONE, QONE);   // tiniest lower distance
        add_word(QONE / 2,          0, 100 * QONE, QONE);
        add_word(QONE - 1,          0, 100 * QONE, QONE);
        add_word(QONE,              0, 100 * QONE, QONE);   // lower band edge
        add_word(50 * QONE,         0, 100 * QONE, QONE);   // clear of both bands
        add_word(99 * QONE,         0, 100 * QONE, QONE);   // upper band edge
        add_word(99 * QONE + 1,     0, 100 * QONE, QONE);
        add_word(100 * QONE - 1,    0, 100 * QONE, QONE);
        add_word(100 * QONE,        0, 100 * QONE, QONE);   // on upper limit
        add_word(100 * QONE + 1,    0, 100 * QONE, QONE);   // just above upper limit
        add_word(0,                 0, 100 * QONE, 0);      // no band, on lower limit
        add_word(100 * QONE,        0, 100 * QONE, 0);      // no band, on upper limit
        add_word(2 * QONE,          0, 4 * QONE, 3 * QONE); // overlapping bands
        add_word(5 * QONE,  10 * QONE, 0, QONE);            // crossed limits
        add_word(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_word(-2,            32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        add_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        add_word(0, 0, 0, 0);
    endtask

    // mostly sane joints with the position near a band, plus full-random noise
    task automatic queue_random(input int n);
        logic [31:0] lo, hi, p;
        logic [31:0] r;
        int unsigned span, off;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(9) < 2) begin
                add_word($urandom, $urandom, $urandom, $urandom);
            end else begin
                r    = $urandom >> $urandom_range(1, 31);
                lo   = $urandom;
                span = $urandom >> $urandom_range(1, 31);
                hi   = lo + span;
                off  = $urandom_range(r);
                case ($urandom_range(7))
                    0: p = lo - $urandom_range(1, 8);
                    1: p = lo + off;
                    2: p = lo;
                    3: p = hi - off;
                    4: p = hi;
                    5: p = hi + $urandom_range(1, 8);
                    6: p = lo + (span >> 1);
                    default: p = $urandom;
                endcase
                add_word(p, lo, hi, r);
            end
        end
    endtask

    // register write followed by a read-back; prdata is compared with the written value
    task automatic cfg_write(input logic idx, input logic [GAIN_W-1:0] val);
        logic [PDATA_W-1:0] rd;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {1'b0, val};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_GAIN) cfg_gain = val;
        else                 cfg_vmax = val;
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== {1'b0, val})
            flag("register read-back", {1'b0, val}, rd);
    endtask

    initial begin
        logic [GAIN_W-1:0] g, v;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < N_PHASE; ph++) begin
            // idling: sender light / receiver heavy, then swapped, then none
            if (ph < 2) begin
                tx_idle_pct = 22;
                rx_idle_pct = 48;
            end else if (ph < 4) begin
                tx_idle_pct = 48;
                rx_idle_pct = 22;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            // phase 0 runs on the reset values; later phases sweep the registers
            if (ph > 0) begin
                case (ph)
                    1: begin g = '1; v = '1; end
                    2: begin g = '0; v = '1; end
                    3: begin g = '1; v = '0; end
                    4: begin
                        g = GAIN_W'($urandom_range(1 << 20));
                        v = GAIN_W'($urandom_range(1 << 24));
                    end
                    5: begin g = GAIN_W'(3 * QONE); v = GAIN_W'(10 * QONE); end
                    default: begin g = GAIN_W'($urandom); v = GAIN_W'($urandom); end
                endcase
                cfg_write(REG_GAIN, g);
                cfg_write(REG_VMAX, v);
            end

            // backpressure: receiver stalls long enough to fill the queue and pipeline
            if (ph == 4) rx_hold_req = 400;

            queue_directed();
            queue_random(N_RAND);

            // sender waits here until every word has come back, so writes see an idle block
            while (n_taken != n_queued || vel_expected.size() != 0) @(negedge i_clk);
        end

        // nothing should trickle out after the last expected word
        repeat (TAIL) @(posedge i_clk);
        if (n_bad == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // hard stop far beyond the slowest legal run
    initial begin
        #400000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[joint_limit_avoidance_velocity.f]
rtl/jlav_pkg.sv
rtl/jlav_front.sv
rtl/jlav_queue.sv
rtl/jlav_back.sv
rtl/joint_limit_avoidance_velocity.sv
tb/sv/joint_limit_avoidance_velocity_tb.sv
